// ===== rtl/core/queue_with_prefix_reversal_top_macros.svh =====
// Assertion helpers for the block's top-level RTL file.
`ifndef QUEUE_WITH_PREFIX_REVERSAL_TOP_MACROS_SVH
`define QUEUE_WITH_PREFIX_REVERSAL_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define QWPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qwpr assertion failed");

// Next-cycle implication, disabled while in reset.
`define QWPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qwpr assertion failed");

`endif

// ===== rtl/core/qwpr_pkg.sv =====
package qwpr_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam logic [2:0] KIND_PUSH  = 3'd0;
	localparam logic [2:0] KIND_POP   = 3'd1;
	localparam logic [2:0] KIND_REV   = 3'd2;
	localparam logic [2:0] KIND_FLIP  = 3'd3;
	localparam logic [2:0] KIND_QUERY = 3'd4;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] push_value;
		logic [4:0]         flip_count;
	} cmd_word_t;

	typedef struct packed {
		logic signed [31:0] front_value;
		logic               is_empty;
		logic [4:0]         entry_count;
		logic               op_error;
	} result_word_t;

	typedef struct packed {
		logic we;
		logic re;
	} store_ctrl_t;

endpackage

// ===== rtl/core/queue_with_prefix_reversal_top.sv =====
// Bounded queue of signed 32-bit words with pop, push, reverse-all and
// prefix flip (reverse the first k entries).
// Command channel: cmd is taken at a rising edge with start high and busy
// low. busy stays high until the result has been shown.
// Result channel: result is valid for exactly one cycle with done high;
// the receiver cannot stall, so each result must be taken in that cycle.
// Sequence: push, pop, reverse-all and query pass EXEC, FRONT and RESP, with
// done high in RESP; a prefix flip of k entries (clamped to the count) with
// k above one adds SW_RD, SW_WA and SW_WB for each of its floor(k/2) swapped
// pairs, at most floor(DEPTH/2), between EXEC and FRONT. busy drops the cycle
// after done; no new command is taken before then. The swap loop is set by
// the store's single write port: each pair is one dual read and two writes.
// Reverse-all flips a direction bit and moves the head in one step.
// Reset clears head, count, direction and the sequencer; store contents
// are undefined until written and are never shown before that.
// push on full and pop on empty flag op_error and change nothing.
module queue_with_prefix_reversal_top #(
	parameter int DEPTH = qwpr_pkg::DEPTH_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  qwpr_pkg::cmd_word_t    cmd,
	output logic                   busy,
	output logic                   done,
	output qwpr_pkg::result_word_t result
);

	`include "queue_with_prefix_reversal_top_macros.svh"

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int KW = (CW > 5) ? CW : 5;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_SW_RD = 3'd2;
	localparam logic [2:0] ST_SW_WA = 3'd3;
	localparam logic [2:0] ST_SW_WB = 3'd4;
	localparam logic [2:0] ST_FRONT = 3'd5;
	localparam logic [2:0] ST_RESP  = 3'd6;

	logic [2:0]          state_q;
	qwpr_pkg::cmd_word_t cmd_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic                rev_q;
	logic                err_q;
	logic [AW-1:0]       a_q;
	logic [AW-1:0]       b_q;
	logic [CW-1:0]       pairs_q;

	// shared slot unit: logical position -> store slot
	logic [CW-1:0] pos;
	logic [SW-1:0] sum;
	logic [AW-1:0] slot;
	logic [CW-1:0] k_clamp;
	logic [AW-1:0] a_next;
	logic [AW-1:0] b_next;
	logic          full;
	logic          empty;

	qwpr_pkg::store_ctrl_t ctrl;
	logic [AW-1:0]         waddr;
	logic [31:0]           wdata;
	logic [AW-1:0]         raddr_a;
	logic [31:0]           rdata_a;
	logic [31:0]           rdata_b;

	function automatic logic [AW-1:0] step_up(input logic [AW-1:0] x);
		return (x == AW'(DEPTH - 1)) ? '0 : x + 1'b1;
	endfunction

	function automatic logic [AW-1:0] step_dn(input logic [AW-1:0] x);
		return (x == '0) ? AW'(DEPTH - 1) : x - 1'b1;
	endfunction

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		if (KW'(cmd_q.flip_count) > KW'(count_q)) begin
			k_clamp = count_q;
		end else begin
			k_clamp = CW'(cmd_q.flip_count);
		end
	end

	always_comb begin
		unique case (cmd_q.kind)
			qwpr_pkg::KIND_PUSH: pos = count_q;
			qwpr_pkg::KIND_POP:  pos = CW'(1);
			qwpr_pkg::KIND_REV:  pos = count_q - 1'b1;
			qwpr_pkg::KIND_FLIP: pos = k_clamp - 1'b1;
			default:             pos = '0;
		endcase
		if (rev_q) begin
			sum = SW'(head_q) + SW'(DEPTH) - SW'(pos);
		end else begin
			sum = SW'(head_q) + SW'(pos);
		end
		if (sum >= SW'(DEPTH)) begin
			slot = AW'(sum - SW'(DEPTH));
		end else begin
			slot = AW'(sum);
		end
	end

	assign a_next = rev_q ? step_dn(a_q) : step_up(a_q);
	assign b_next = rev_q ? step_up(b_q) : step_dn(b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					err_q   <= 1'b0;
					state_q <= ST_FRONT;
					unique case (cmd_q.kind)
						qwpr_pkg::KIND_PUSH: begin
							if (full) begin
								err_q <= 1'b1;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
						qwpr_pkg::KIND_POP: begin
							if (empty) begin
								err_q <= 1'b1;
							end else begin
								head_q  <= slot;
								count_q <= count_q - 1'b1;
							end
						end
						qwpr_pkg::KIND_REV: begin
							if (!empty) begin
								head_q <= slot;
								rev_q  <= !rev_q;
							end
						end
						qwpr_pkg::KIND_FLIP: begin
							if (k_clamp > CW'(1)) begin
								state_q <= ST_SW_RD;
							end
						end
						default: begin
						end
					endcase
				end
				ST_SW_RD: state_q <= ST_SW_WA;
				ST_SW_WA: state_q <= ST_SW_WB;
				ST_SW_WB: begin
					state_q <= (pairs_q == CW'(1)) ? ST_FRONT : ST_SW_RD;
				end
				ST_FRONT: state_q <= ST_RESP;
				ST_RESP:  state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// payload and swap pointers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_EXEC) begin
			a_q     <= head_q;
			b_q     <= slot;
			pairs_q <= k_clamp >> 1;
		end else if (state_q == ST_SW_WB) begin
			a_q     <= a_next;
			b_q     <= b_next;
			pairs_q <= pairs_q - 1'b1;
		end
	end

	always_comb begin
		ctrl    = '0;
		waddr   = slot;
		wdata   = cmd_q.push_value;
		raddr_a = a_q;
		unique case (state_q)
			ST_EXEC: begin
				ctrl.we = (cmd_q.kind == qwpr_pkg::KIND_PUSH) && !full;
			end
			ST_SW_RD: ctrl.re = 1'b1;
			ST_SW_WA: begin
				ctrl.we = 1'b1;
				waddr   = a_q;
				wdata   = rdata_b;
			end
			ST_SW_WB: begin
				ctrl.we = 1'b1;
				waddr   = b_q;
				wdata   = rdata_a;
			end
			ST_FRONT: begin
				ctrl.re = 1'b1;
				raddr_a = head_q;
			end
			default: begin
			end
		endcase
	end

	qwpr_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk     (clk),
		.ctrl    (ctrl),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (b_q),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

	always_comb begin
		result.front_value = empty ? 32'sd0 : $signed(rdata_a);
		result.is_empty    = empty;
		result.entry_count = 5'(count_q);
		result.op_error    = err_q;
	end

	`QWPR_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`QWPR_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy && !done)
	`QWPR_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`QWPR_ASSERT_NOW(a_empty_zero, clk, arst_n, done && result.is_empty,
		result.front_value == 32'sd0)

endmodule

// ===== rtl/core/qwpr_store.sv =====
module qwpr_store #(
	parameter int DEPTH = qwpr_pkg::DEPTH_DEFAULT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  qwpr_pkg::store_ctrl_t ctrl,
	input  logic [AW-1:0]         waddr,
	input  logic [31:0]           wdata,
	input  logic [AW-1:0]         raddr_a,
	input  logic [AW-1:0]         raddr_b,
	output logic [31:0]           rdata_a,
	output logic [31:0]           rdata_b
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.re) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int DEPTH = qwpr_pkg::DEPTH_DEFAULT;
	localparam int LONGEST_OP = 3 + 3 * (DEPTH / 2) + 1;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_WORDS = 1000;
	localparam int PHASE_LEN = 60;

	// kind codes beyond query-only; the block treats them as query
	localparam logic [2:0] KIND_RSVD5 = 3'd5;
	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;

	typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} traffic_mode_t;

	typedef struct {
		qwpr_pkg::cmd_word_t    word;
		int                     reps;
		bit                     pinned;
		qwpr_pkg::result_word_t want;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	qwpr_pkg::cmd_word_t    cmd = '0;
	logic                   busy;
	logic                   done;
	qwpr_pkg::result_word_t result;

	queue_with_prefix_reversal_top #(.DEPTH(DEPTH)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// shadow of the queue
	logic signed [31:0] shadow_store [DEPTH];
	int                 shadow_head = 0;
	int                 shadow_count = 0;
	bit                 shadow_rev = 1'b0;

	qwpr_pkg::result_word_t pending_results[$];
	stim_row_t              directed_rows[$];
	int                     mismatches = 0;
	int                     words_sent = 0;
	int                     flips_sent = 0;
	int                     error_words = 0;
	int                     peak_count = 0;
	int                     quiet_cycles = 0;
	bit                     allow_idle = 1'b1;

	function automatic int slot_at(int pos);
		int p;
		p = pos % DEPTH;
		if (shadow_rev)
			return (shadow_head + DEPTH - p) % DEPTH;
		return (shadow_head + p) % DEPTH;
	endfunction

	function automatic qwpr_pkg::result_word_t queue_apply(qwpr_pkg::cmd_word_t w);
		qwpr_pkg::result_word_t r;
		int k;
		int a;
		int b;
		logic signed [31:0] t;
		r = '0;
		case (w.kind)
			qwpr_pkg::KIND_PUSH: begin
				if (shadow_count >= DEPTH) begin
					r.op_error = 1'b1;
				end else begin
					shadow_store[slot_at(shadow_count)] = w.push_value;
					shadow_count++;
				end
			end
			qwpr_pkg::KIND_POP: begin
				if (shadow_count == 0) begin
					r.op_error = 1'b1;
				end else begin
					shadow_head = slot_at(1);
					shadow_count--;
				end
			end
			qwpr_pkg::KIND_REV: begin
				if (shadow_count > 0) begin
					shadow_head = slot_at(shadow_count - 1);
					shadow_rev = !shadow_rev;
				end
			end
			qwpr_pkg::KIND_FLIP: begin
				k = (w.flip_count > shadow_count) ? shadow_count : int'(w.flip_count);
				for (int i = 0; i < k / 2; i++) begin
					a = slot_at(i);
					b = slot_at(k - 1 - i);
					t = shadow_store[a];
					shadow_store[a] = shadow_store[b];
					shadow_store[b] = t;
				end
			end
			default: ;
		endcase
		r.front_value = shadow_count ? shadow_store[slot_at(0)] : 32'sd0;
		r.is_empty = (shadow_count == 0);
		r.entry_count = shadow_count[4:0];
		return r;
	endfunction

	function automatic qwpr_pkg::result_word_t res(logic [31:0] front, bit empty, int count,
			bit err);
		qwpr_pkg::result_word_t r;
		r.front_value = front;
		r.is_empty = empty;
		r.entry_count = count[4:0];
		r.op_error = err;
		return r;
	endfunction

	function automatic stim_row_t row(logic [2:0] kind, logic [31:0] value, int k, int reps,
			bit pinned, qwpr_pkg::result_word_t want);
		stim_row_t s;
		s.word.kind = kind;
		s.word.push_value = value;
		s.word.flip_count = k[4:0];
		s.reps = reps;
		s.pinned = pinned;
		s.want = want;
		return s;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
	endtask

	// one command in flight at most; the word leaves start high when no idle follows
	task automatic send_word(qwpr_pkg::cmd_word_t w, bit pinned, qwpr_pkg::result_word_t want);
		qwpr_pkg::result_word_t predicted;
		start <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = queue_apply(w);
		pending_results.push_back(pinned ? want : predicted);
		words_sent++;
		if (w.kind == qwpr_pkg::KIND_FLIP)
			flips_sent++;
		if (predicted.op_error)
			error_words++;
		if (shadow_count > peak_count)
			peak_count = shadow_count;
		if (allow_idle && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic qwpr_pkg::cmd_word_t random_word(traffic_mode_t mode);
		qwpr_pkg::cmd_word_t w;
		int roll;
		int push_pct;
		int pop_pct;
		push_pct = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 10 : 30;
		pop_pct = (mode == MODE_DRAIN) ? 55 : (mode == MODE_FILL) ? 10 : 25;
		roll = $urandom_range(0, 99);
		w.push_value = $urandom;
		w.flip_count = 5'($urandom_range(0, 31));
		if (roll < push_pct)
			w.kind = qwpr_pkg::KIND_PUSH;
		else if (roll < push_pct + pop_pct)
			w.kind = qwpr_pkg::KIND_POP;
		else if (roll < push_pct + pop_pct + 8)
			w.kind = qwpr_pkg::KIND_REV;
		else if (roll < 96)
			w.kind = qwpr_pkg::KIND_FLIP;
		else if (roll == 96)
			w.kind = qwpr_pkg::KIND_QUERY;
		else if (roll == 97)
			w.kind = KIND_RSVD5;
		else if (roll == 98)
			w.kind = KIND_RSVD6;
		else
			w.kind = KIND_RSVD7;
		if (w.kind == qwpr_pkg::KIND_FLIP && $urandom_range(0, 99) < 80)
			w.flip_count = 5'($urandom_range(0, shadow_count + 1));
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: w.push_value = 32'sh7fffffff;
				1: w.push_value = 32'sh80000000;
				2: w.push_value = 32'sd0;
				default: w.push_value = -32'sd1;
			endcase
		end
		return w;
	endfunction

	always @(posedge clk) begin
		qwpr_pkg::result_word_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report("unexpected word", 64'(result), '0);
			end else begin
				want = pending_results.pop_front();
				if (result.front_value !== want.front_value)
					report("front_value", 64'(result.front_value), 64'(want.front_value));
				if (result.is_empty !== want.is_empty)
					report("is_empty", 64'(result.is_empty), 64'(want.is_empty));
				if (result.entry_count !== want.entry_count)
					report("entry_count", 64'(result.entry_count), 64'(want.entry_count));
				if (result.op_error !== want.op_error)
					report("op_error", 64'(result.op_error), 64'(want.op_error));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: timeout, no handshake for %0d cycles", STALL_LIMIT);
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		qwpr_pkg::cmd_word_t w;
		traffic_mode_t mode;
		stim_row_t s;

		// empty queue corners
		directed_rows.push_back(row(qwpr_pkg::KIND_QUERY, 32'h0, 0, 1, 1, res(0, 1, 0, 0)));
		directed_rows.push_back(row(qwpr_pkg::KIND_POP, 32'h0, 0, 1, 1, res(0, 1, 0, 1)));
		directed_rows.push_back(row(qwpr_pkg::KIND_REV, 32'h0, 0, 1, 1, res(0, 1, 0, 0)));
		directed_rows.push_back(row(qwpr_pkg::KIND_FLIP, 32'h0, 16, 1, 1, res(0, 1, 0, 0)));
		// value extremes
		directed_rows.push_back(row(qwpr_pkg::KIND_PUSH, 32'h7fffffff, 0, 1, 1,
			res(32'h7fffffff, 0, 1, 0)));
		directed_rows.push_back(row(qwpr_pkg::KIND_PUSH, 32'h80000000, 0, 1, 1,
			res(32'h7fffffff, 0, 2, 0)));
		directed_rows.push_back(row(qwpr_pkg::KIND_PUSH, 32'h0, 0, 1, 0, '0));
		directed_rows.push_back(row(qwpr_pkg::KIND_PUSH, 32'hffffffff, 0, 1, 0, '0));
		// flip count above the count clamps to a full flip
		directed_rows.push_back(row(qwpr_pkg::KIND_FLIP, 32'h0, 31, 1, 1,
			res(32'hffffffff, 0, 4, 0)));
		directed_rows.push_back(row(qwpr_pkg::KIND_FLIP, 32'h0, 0, 1, 1,
			res(32'hffffffff, 0, 4, 0)));
		directed_rows.push_back(row(qwpr_pkg::KIND_FLIP, 32'h0, 1, 1, 1,
			res(32'hffffffff, 0, 4, 0)));
		directed_rows.push_back(row(qwpr_pkg::KIND_REV, 32'h0, 0, 1, 1,
			res(32'h7fffffff, 0, 4, 0)));
		// fill in reversed order, then push on full
		directed_rows.push_back(row(qwpr_pkg::KIND_PUSH, 32'h1000, 0, 12, 0, '0));
		directed_rows.push_back(row(qwpr_pkg::KIND_PUSH, 32'h5, 0, 1, 1,
			res(32'h7fffffff, 0, 16, 1)));
		directed_rows.push_back(row(qwpr_pkg::KIND_FLIP, 32'h0, 16, 1, 0, '0));
		directed_rows.push_back(row(qwpr_pkg::KIND_FLIP, 32'h0, 7, 1, 0, '0));
		directed_rows.push_back(row(qwpr_pkg::KIND_REV, 32'h0, 0, 1, 0, '0));
		directed_rows.push_back(row(KIND_RSVD5, 32'hdeadbeef, 9, 1, 0, '0));
		directed_rows.push_back(row(KIND_RSVD6, 32'h12345678, 31, 1, 0, '0));
		directed_rows.push_back(row(KIND_RSVD7, 32'hffffffff, 16, 1, 0, '0));
		directed_rows.push_back(row(qwpr_pkg::KIND_POP, 32'h0, 0, 15, 0, '0));
		directed_rows.push_back(row(qwpr_pkg::KIND_POP, 32'h0, 0, 1, 1, res(0, 1, 0, 0)));
		directed_rows.push_back(row(qwpr_pkg::KIND_POP, 32'h0, 0, 1, 1, res(0, 1, 0, 1)));
		directed_rows.push_back(row(qwpr_pkg::KIND_PUSH, 32'h55aa55aa, 0, 1, 1,
			res(32'h55aa55aa, 0, 1, 0)));
		directed_rows.push_back(row(qwpr_pkg::KIND_REV, 32'h0, 0, 1, 1,
			res(32'h55aa55aa, 0, 1, 0)));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			s = directed_rows[i];
			for (int j = 0; j < s.reps; j++) begin
				w = s.word;
				w.push_value = 32'(s.word.push_value + j);
				send_word(w, s.pinned, s.want);
			end
		end
		hold_until_drained();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// a calm stretch with back-to-back commands
			allow_idle = !(n >= 400 && n < 700);
			if (allow_idle && n > 0 && n % PHASE_LEN == 0)
				hold_until_drained();
			case ((n / PHASE_LEN) % 4)
				0: mode = MODE_FILL;
				2: mode = MODE_DRAIN;
				default: mode = MODE_MIX;
			endcase
			send_word(random_word(mode), 1'b0, '0);
		end

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LONGEST_OP) @(posedge clk);

		$display("tb: %0d commands sent, %0d prefix flips, %0d error words", words_sent,
			flips_sent, error_words);
		$display("tb: peak occupancy %0d of %0d, %0d mismatches", peak_count, DEPTH, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
